// ===== src/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg - shared types and constants of the streaming prime sieve
// Field widths, status and command codes, and the beat that moves down the
// cell chain.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int PRIME_W       = 26;   // base prime width
  localparam int NUM_W         = 53;   // candidate / multiple width
  localparam int LOW_W         = 52;   // range_low register width
  localparam int CFG_IDX_W     = 1;
  localparam int NUM_CELLS_DEF = 1024;

  localparam logic [LOW_W-1:0] LOW_FLOOR = LOW_W'(100);
  localparam logic [NUM_W-1:0] HIGH_CEIL = NUM_W'(1) << 52;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  typedef enum logic [2:0] {
    ST_COMPOSITE = 3'd0,
    ST_PRIME     = 3'd1,
    ST_PAST      = 3'd2,
    ST_LOADED    = 3'd3,
    ST_DROPPED   = 3'd4
  } status_t;

  // One beat in the chain. For tests number is the candidate; for loads
  // number carries the first odd multiple and aux the base prime.
  typedef struct packed {
    logic               valid;
    status_t            status;
    logic               last;
    logic               pend;    // load still looking for a free cell
    logic [NUM_W-1:0]   number;
    logic [PRIME_W-1:0] aux;
  } beat_t;

  // Chain-wide control
  typedef struct packed {
    logic adv;   // every stage moves one place
    logic clr;   // forget all stored primes
  } ctl_t;

endpackage

// ===== src/sps_rem.sv =====
// ----------------------------------------------------------------------------
// sps_rem - bit-serial remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module sps_rem
  import sps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [PRIME_W-1:0] divisor,
  output logic               busy,
  output logic [PRIME_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]   cnt;
  logic [PRIME_W-1:0] rem_q;
  logic [NUM_W-1:0]   shreg;
  logic [PRIME_W:0]   trial;
  logic [PRIME_W:0]   diff;
  logic               ge;

  assign trial = {rem_q, shreg[NUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      shreg <= dividend;
    end else if (cnt != '0) begin
      shreg <= shreg << 1;
      rem_q <= ge ? diff[PRIME_W-1:0] : trial[PRIME_W-1:0];
    end
  end

  assign busy = cnt != '0;
  assign rem  = rem_q;

endmodule

// ===== src/sps_cell.sv =====
// ----------------------------------------------------------------------------
// sps_cell - one sieve cell
// Holds one base prime and its next odd multiple; claims the first load that
// reaches it empty, strikes matching candidates and steps its multiple.
// ----------------------------------------------------------------------------
module sps_cell
  import sps_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl,
  input  beat_t beat_in,
  output beat_t beat_out
);

  logic               used;
  logic [PRIME_W-1:0] prime;
  logic [NUM_W-1:0]   mult;
  logic               is_test;
  logic               hit;
  logic               claim;
  beat_t              beat_next;

  always_comb begin
    is_test = beat_in.valid &&
              (beat_in.status == ST_PRIME || beat_in.status == ST_COMPOSITE);
    hit     = is_test && used && (mult == beat_in.number);
    claim   = beat_in.valid && beat_in.pend && !used;

    beat_next = beat_in;
    if (hit) begin
      beat_next.status = ST_COMPOSITE;
    end
    if (claim) begin
      beat_next.pend = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= 1'b0;
      beat_out <= '0;
    end else if (ctl.clr) begin
      used <= 1'b0;
    end else if (ctl.adv) begin
      beat_out <= beat_next;
      if (claim) begin
        used <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && claim) begin
      prime <= beat_in.aux;
      mult  <= beat_in.number;
    end else if (ctl.adv && hit) begin
      mult <= mult + NUM_W'({prime, 1'b0});
    end
  end

endmodule

// ===== src/sps_head.sv =====
// ----------------------------------------------------------------------------
// sps_head - sieve front end
// Keeps the candidate counter, bounds and fill count, works out the first
// multiple of a new base prime; feeds one beat a cycle while the chain moves.
// ----------------------------------------------------------------------------
module sps_head
  import sps_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_func,
  input  logic [PRIME_W-1:0]   in_prime,
  output logic                 in_ready,
  input  logic                 adv,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NUM_W-1:0]     cfg_data,
  output logic                 clr,
  output beat_t                beat
);

  localparam int USED_W = $clog2(NUM_CELLS + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQUARE = 7'b0000010,
    S_SELECT = 7'b0000100,
    S_DIVIDE = 7'b0001000,
    S_ROUND  = 7'b0010000,
    S_ODD    = 7'b0100000,
    S_ISSUE  = 7'b1000000
  } state_t;

  state_t              state, state_next;
  logic [NUM_W-1:0]    cand;       // next odd candidate
  logic [NUM_W-1:0]    hi;         // clamped upper bound
  logic [USED_W-1:0]   used_cnt;
  logic [PRIME_W-1:0]  p_q;
  logic [2*PRIME_W-1:0] sq_q;
  logic [NUM_W-1:0]    t_q;
  logic [NUM_W:0]      m_q;

  logic                take;
  logic                past;
  logic [NUM_W:0]      cand_plus2;
  logic                full;
  logic                load_ok;
  logic [NUM_W-1:0]    t_sel;
  logic                rem_busy;
  logic [PRIME_W-1:0]  rem;
  logic [PRIME_W-1:0]  rem_gap;
  logic [LOW_W-1:0]    lo_eff;
  beat_t               beat_next;

  sps_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SELECT),
    .dividend (t_sel),
    .divisor  (p_q),
    .busy     (rem_busy),
    .rem      (rem)
  );

  always_comb begin
    in_ready   = (state == S_IDLE) && adv && !rst;
    take       = in_valid && in_ready;
    past       = cand > hi;
    cand_plus2 = {1'b0, cand} + (NUM_W+1)'(2);
    full       = used_cnt == USED_W'(NUM_CELLS);
    load_ok    = (in_prime >= PRIME_W'(3)) && in_prime[0] && !full;
    t_sel      = (NUM_W'(sq_q) > cand) ? NUM_W'(sq_q) : cand;
    rem_gap    = (rem == '0) ? '0 : p_q - rem;
    lo_eff     = (cfg_data[LOW_W-1:0] < LOW_FLOOR) ? LOW_FLOOR : cfg_data[LOW_W-1:0];
    clr        = cfg_we && (cfg_index == REG_RANGE_LOW);

    beat_next = '0;
    if (state == S_ISSUE) begin
      beat_next.valid  = 1'b1;
      beat_next.status = ST_LOADED;
      beat_next.pend   = 1'b1;
      beat_next.number = m_q[NUM_W-1:0];
      beat_next.aux    = p_q;
    end else if (take && in_func == FUNC_TEST) begin
      beat_next.valid  = 1'b1;
      beat_next.status = past ? ST_PAST : ST_PRIME;
      beat_next.last   = !past && (cand_plus2 > {1'b0, hi});
      beat_next.number = cand;
    end else if (take && !load_ok) begin
      beat_next.valid  = 1'b1;
      beat_next.status = ST_DROPPED;
      beat_next.aux    = in_prime;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (take && in_func == FUNC_LOAD && load_ok) state_next = S_SQUARE;
      S_SQUARE: state_next = S_SELECT;
      S_SELECT: state_next = S_DIVIDE;
      S_DIVIDE: if (!rem_busy) state_next = S_ROUND;
      S_ROUND:  state_next = S_ODD;
      S_ODD:    state_next = S_ISSUE;
      S_ISSUE:  if (adv) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cand     <= NUM_W'(LOW_FLOOR) + NUM_W'(1);
      hi       <= HIGH_CEIL;
      used_cnt <= '0;
      beat     <= '0;
    end else begin
      state <= state_next;
      if (adv) begin
        beat <= beat_next;
      end
      priority if (cfg_we) begin
        unique case (cfg_index)
          REG_RANGE_LOW: begin
            cand     <= ({1'b0, lo_eff} + NUM_W'(1)) | NUM_W'(1);
            used_cnt <= '0;
          end
          REG_RANGE_HIGH: hi <= (cfg_data > HIGH_CEIL) ? HIGH_CEIL : cfg_data;
          default: ;
        endcase
      end else if (take && in_func == FUNC_TEST && !past) begin
        cand <= cand_plus2[NUM_W-1:0];
      end else if (take && in_func == FUNC_LOAD && load_ok) begin
        used_cnt <= used_cnt + USED_W'(1);
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_q <= in_prime;
    end
    if (state == S_SQUARE) begin
      sq_q <= p_q * p_q;
    end
    if (state == S_SELECT) begin
      t_q <= t_sel;
    end
    if (state == S_ROUND) begin
      m_q <= {1'b0, t_q} + (NUM_W+1)'(rem_gap);
    end else if (state == S_ODD && !m_q[0]) begin
      m_q <= m_q + (NUM_W+1)'(p_q);
    end
  end

endmodule

// ===== src/streaming_prime_sieve_core.sv =====
// ----------------------------------------------------------------------------
// streaming_prime_sieve_core - segmented sieve of Eratosthenes, cell chain
// Slave stream: tuser = func (0 load base prime, 1 test next odd candidate),
//   tdata = base prime. Master stream: tuser = status, tdata = number,
//   tlast = final candidate not above range_high.
// Config port: cfg_we / cfg_index / cfg_data, written only while idle; the
//   user must keep to this, the block leaves it unchecked. Writing range_low
//   restarts the candidate and empties the cell table.
// Path: every beat walks the whole chain, one cell per cycle while it moves,
//   then the output register; a usable load first works out its multiple.
// Throughput: a test beat is taken every cycle while the chain moves and no
//   load is in work. A usable base-prime load holds the slave side through a
//   26x26 square, a bit-serial remainder of 53 steps, then two rounding adds.
// Reset: table empty, range (100, 2^52], first candidate 101. No clearing
//   pass; ready comes up as soon as reset drops.
// Stall: the output register loads when empty or taken; a waiting result
//   blocks the chain only when the last cell also holds a beat.
// ----------------------------------------------------------------------------
module streaming_prime_sieve_core
  import sps_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [25:0] base_prime, rest zero
  input  logic                 s_tuser,   // [0] func
  // master stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // [52:0] number, rest zero
  output logic [2:0]           m_tuser,   // [2:0] status
  output logic                 m_tlast,   // final candidate in range
  // config
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NUM_W-1:0]     cfg_data
);

  beat_t            chain [0:NUM_CELLS];
  ctl_t             ctl;
  logic             clr;
  logic             out_valid;
  status_t          out_status;
  logic             out_last;
  logic [NUM_W-1:0] out_number;
  logic             out_load;
  logic             tail_is_load;

  // chain moves unless the last cell and the output register are both full
  // and the receiver is stalling
  assign out_load = !out_valid || m_tready;
  assign ctl.adv  = !chain[NUM_CELLS].valid || out_load;
  assign ctl.clr  = clr;

  sps_head #(.NUM_CELLS(NUM_CELLS)) u_head (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_func   (s_tuser),
    .in_prime  (s_tdata[PRIME_W-1:0]),
    .in_ready  (s_tready),
    .adv       (ctl.adv),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clr       (clr),
    .beat      (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    sps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  // loads report the base prime, which travels in aux
  assign tail_is_load = chain[NUM_CELLS].status == ST_LOADED ||
                        chain[NUM_CELLS].status == ST_DROPPED;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= chain[NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= chain[NUM_CELLS].status;
      out_last   <= chain[NUM_CELLS].last;
      out_number <= tail_is_load ? NUM_W'(chain[NUM_CELLS].aux)
                                 : chain[NUM_CELLS].number;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_number};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

// ===== src/sps_chk.sv =====
// ----------------------------------------------------------------------------
// sps_chk - port-level checks for the prime sieve
// Watches the top-level ports only; bound onto every instance.
// ----------------------------------------------------------------------------
module sps_chk
  import sps_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [55:0]          m_tdata,
  input logic [2:0]           m_tuser,
  input logic                 m_tlast
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("result beat changed while stalled");

  // tlast only marks a tested candidate
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == ST_PRIME || m_tuser == ST_COMPOSITE)
    else $error("tlast on a non-candidate beat");

  // load results carry the base prime only
  a_load_num: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_LOADED || m_tuser == ST_DROPPED) |->
      m_tdata[55:PRIME_W] == '0)
    else $error("load result wider than a base prime");

  // nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

endmodule

bind streaming_prime_sieve_core sps_chk u_sps_chk (.*);
